[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[design/pmm_pkg.sv]
// ----------------------------------------------------------------------------
// pmm_pkg
// shared types and constants of the pulse period meter
// ----------------------------------------------------------------------------
package pmm_pkg;

  localparam int unsigned NumCh = 3;
  localparam int unsigned ChW   = 2;

  localparam logic [ChW-1:0] LastCh     = ChW'(NumCh - 1);
  localparam logic [15:0]    SatPeriod  = 16'hFFFF;
  localparam logic [7:0]     TickDivRst = 8'd10;

  // per-channel result captured by a lane
  typedef struct packed {
    logic        edge_seen;
    logic [15:0] period;
    logic [15:0] min_period;
    logic [15:0] max_period;
    logic [15:0] window_count;
    logic [31:0] running_sum;
  } lane_res_t;

  // one sample tick as seen by every lane
  typedef struct packed {
    logic accept;
    logic clear_window;
    logic clear_sum;
  } lane_ctl_t;

endpackage

[design/pmm_if.sv]
// ----------------------------------------------------------------------------
// pmm channel interfaces
// tick input and per-channel result output, valid/ready handshake
// ----------------------------------------------------------------------------
interface pmm_in_if;
  logic valid;
  logic ready;
  logic pin_zero;
  logic pin_one;
  logic pin_two;
  logic clear_window;
  logic clear_sum;

  modport source (
    output valid, pin_zero, pin_one, pin_two, clear_window, clear_sum,
    input  ready
  );
  modport sink (
    input  valid, pin_zero, pin_one, pin_two, clear_window, clear_sum,
    output ready
  );
endinterface

interface pmm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  channel;
  logic        edge_seen;
  logic [15:0] period;
  logic [15:0] min_period;
  logic [15:0] max_period;
  logic [15:0] window_count;
  logic [31:0] running_sum;
  logic        ms_strobe;
  logic        last;

  modport source (
    output valid, channel, edge_seen, period, min_period, max_period,
           window_count, running_sum, ms_strobe, last,
    input  ready
  );
  modport sink (
    input  valid, channel, edge_seen, period, min_period, max_period,
           window_count, running_sum, ms_strobe, last,
    output ready
  );
endinterface

[design/pmm_lane.sv]
// ----------------------------------------------------------------------------
// pmm_lane
// one channel: edge detect, period counter, window min/max and counts
// ----------------------------------------------------------------------------
module pmm_lane
  import pmm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_ctl_t ctl_i,
  input  logic      level_i,
  output lane_res_t res_o
);

  logic        prev_q, prev_d;
  logic        counting_q, counting_d;
  logic [15:0] run_q, run_d;
  logic [15:0] latched_q, latched_d;
  logic [15:0] min_q, min_d;
  logic [15:0] max_q, max_d;
  logic [15:0] count_q, count_d;
  logic [31:0] sum_q, sum_d;

  logic        edge_fall;
  logic [15:0] run_inc;

  always_comb begin
    // clears act before this tick's update
    count_d = ctl_i.clear_window ? 16'd0 : count_q;
    min_d   = ctl_i.clear_window ? SatPeriod : min_q;
    max_d   = ctl_i.clear_window ? 16'd0 : max_q;
    sum_d   = ctl_i.clear_sum ? 32'd0 : sum_q;

    run_inc    = (counting_q && run_q != SatPeriod) ? run_q + 16'd1 : run_q;
    edge_fall  = prev_q && !level_i;
    run_d      = run_inc;
    counting_d = counting_q;
    latched_d  = latched_q;

    if (edge_fall) begin
      count_d = count_d + 16'd1;
      sum_d   = sum_d + 32'd1;
      // first edge only starts the counter
      if (counting_q) begin
        latched_d = run_inc;
        if (run_inc < min_d) begin
          min_d = run_inc;
        end
        if (run_inc > max_d && run_inc != SatPeriod) begin
          max_d = run_inc;
        end
      end
      run_d      = 16'd0;
      counting_d = 1'b1;
    end
    prev_d = level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= 1'b0;
      counting_q <= 1'b0;
      run_q      <= 16'd0;
      latched_q  <= 16'd0;
      min_q      <= SatPeriod;
      max_q      <= 16'd0;
      count_q    <= 16'd0;
      sum_q      <= 32'd0;
    end else if (ctl_i.accept) begin
      prev_q     <= prev_d;
      counting_q <= counting_d;
      run_q      <= run_d;
      latched_q  <= latched_d;
      min_q      <= min_d;
      max_q      <= max_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
    end
  end

  assign res_o = '{
    edge_seen:    edge_fall,
    period:       latched_d,
    min_period:   min_d,
    max_period:   max_d,
    window_count: count_d,
    running_sum:  sum_d
  };

endmodule

[design/pmm_merge.sv]
// ----------------------------------------------------------------------------
// pmm_merge
// gathers the lane results of a tick and sends them out one per transaction
// ----------------------------------------------------------------------------
module pmm_merge
  import pmm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  lane_res_t        lane_res_i [NumCh],
  input  logic             strobe_i,
  output logic             free_o,
  pmm_out_if.source        res_o
);

  logic            pend_valid_q;
  lane_res_t       pend_res_q [NumCh];
  logic            pend_strobe_q;

  logic            ser_valid_q;
  lane_res_t       ser_res_q [NumCh];
  logic            ser_strobe_q;
  logic [ChW-1:0]  idx_q;

  logic            out_acc;
  logic            ser_done;
  logic            load_ser;
  lane_res_t       cur;

  assign out_acc  = res_o.valid && res_o.ready;
  assign ser_done = out_acc && (idx_q == LastCh);
  assign load_ser = pend_valid_q && (!ser_valid_q || ser_done);
  assign free_o   = !pend_valid_q;

  // staging buffer, one tick deep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (load_i) begin
      pend_valid_q <= 1'b1;
    end else if (load_ser) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pend_res_q    <= lane_res_i;
      pend_strobe_q <= strobe_i;
    end
  end

  // output stage walks through the channels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load_ser) begin
      ser_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (ser_done) begin
      ser_valid_q <= 1'b0;
    end else if (out_acc) begin
      idx_q <= idx_q + ChW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ser) begin
      ser_res_q    <= pend_res_q;
      ser_strobe_q <= pend_strobe_q;
    end
  end

  assign cur = ser_res_q[idx_q];

  assign res_o.valid        = ser_valid_q;
  assign res_o.channel      = idx_q;
  assign res_o.edge_seen    = cur.edge_seen;
  assign res_o.period       = cur.period;
  assign res_o.min_period   = cur.min_period;
  assign res_o.max_period   = cur.max_period;
  assign res_o.window_count = cur.window_count;
  assign res_o.running_sum  = cur.running_sum;
  assign res_o.ms_strobe    = ser_strobe_q;
  assign res_o.last         = (idx_q == LastCh);

endmodule

[design/multi_channel_pulse_period_meter.sv]
// ----------------------------------------------------------------------------
// multi_channel_pulse_period_meter
// three-channel pulse period meter with window min/max and edge counts
// ----------------------------------------------------------------------------
// Each accepted tick transaction updates all three channel lanes in the same
// cycle and yields three result transactions, channel 0 to 2, with last set on
// channel 2. The results leave through a single output register one per
// cycle while the result channel is ready; the first result of a tick passes
// through the staging buffer and then the output register. A one-tick staging
// buffer lets the next tick be taken while the previous tick's results are
// still going out. tick_divide is written through cfg_we_i/cfg_wdata_i and
// does not reset the millisecond divider.
`include "assert_macros.svh"

module multi_channel_pulse_period_meter
  import pmm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  pmm_in_if.sink     tick_i,
  pmm_out_if.source  res_o
);

  logic       tick_acc;
  logic       merge_free;
  lane_ctl_t  ctl;
  logic [NumCh-1:0] levels;
  lane_res_t  lane_res [NumCh];

  logic [7:0] tick_div_q;
  logic [7:0] tick_cnt_q, tick_cnt_d;
  logic [7:0] tick_inc;
  logic       strobe;

  assign tick_i.ready = merge_free;
  assign tick_acc     = tick_i.valid && tick_i.ready;

  assign ctl = '{
    accept:       tick_acc,
    clear_window: tick_i.clear_window,
    clear_sum:    tick_i.clear_sum
  };
  assign levels = {tick_i.pin_two, tick_i.pin_one, tick_i.pin_zero};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_div_q <= TickDivRst;
    end else if (cfg_we_i) begin
      tick_div_q <= cfg_wdata_i;
    end
  end

  // millisecond divider, wraps through 255 when it misses the match
  assign tick_inc   = tick_cnt_q + 8'd1;
  assign strobe     = (tick_inc == tick_div_q);
  assign tick_cnt_d = strobe ? 8'd0 : tick_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_cnt_q <= 8'd0;
    end else if (tick_acc) begin
      tick_cnt_q <= tick_cnt_d;
    end
  end

  for (genvar c = 0; c < NumCh; c++) begin : g_lane
    pmm_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .level_i (levels[c]),
      .res_o   (lane_res[c])
    );
  end

  pmm_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (tick_acc),
    .lane_res_i (lane_res),
    .strobe_i   (strobe),
    .free_o     (merge_free),
    .res_o      (res_o)
  );

  `ASSERT_SAME(a_last_on_final_ch, clk_i, rst_ni, res_o.valid, res_o.last == (res_o.channel == LastCh))
  `ASSERT_SAME(a_ch_in_range, clk_i, rst_ni, res_o.valid, res_o.channel != 2'd3)
  `ASSERT_SAME(a_max_unsat, clk_i, rst_ni, res_o.valid, res_o.max_period != SatPeriod)
  `ASSERT_NEXT(a_stage_fills, clk_i, rst_ni, tick_acc, !tick_i.ready)

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-channel pulse period meter. Tick
// transactions go in through the input channel with random gaps, and each
// one is run through a local model of the meter. The model's three
// per-channel results are queued. The result channel is stalled at random,
// and every result is compared field by field with the oldest queued one.
// The divider is reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb;
  import pmm_pkg::*;

  typedef struct packed {
    logic [ChW-1:0] channel;
    lane_res_t      lane;
    logic           ms_strobe;
    logic           last;
  } meter_result_t;

  class meter_scoreboard;
    logic [7:0]    divide;
    logic [7:0]    tick_count;
    logic [2:0]    prev_lvl;
    logic [2:0]    active;
    logic [15:0]   run_per [NumCh];
    logic [15:0]   held_per [NumCh];
    logic [15:0]   min_per [NumCh];
    logic [15:0]   max_per [NumCh];
    logic [15:0]   win_cnt [NumCh];
    logic [31:0]   edge_sum [NumCh];
    meter_result_t expected_q [$];
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   strobes;
    int unsigned   falls;
    int unsigned   saturated;

    function new();
      divide     = TickDivRst;
      tick_count = '0;
      prev_lvl   = '0;
      active     = '0;
      for (int c = 0; c < NumCh; c++) begin
        run_per[c]  = '0;
        held_per[c] = '0;
        min_per[c]  = SatPeriod;
        max_per[c]  = '0;
        win_cnt[c]  = '0;
        edge_sum[c] = '0;
      end
      mismatches = 0;
      checked    = 0;
      strobes    = 0;
      falls      = 0;
      saturated  = 0;
    endfunction

    function void set_divide(logic [7:0] v);
      divide = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // one accepted tick transaction gives three expected results
    function void note_tick(logic [2:0] lvl, logic clr_win, logic clr_sum);
      logic [2:0]    fell;
      logic          strobe;
      meter_result_t r;
      fell   = '0;
      strobe = 1'b0;
      if (clr_win) begin
        for (int c = 0; c < NumCh; c++) begin
          win_cnt[c] = '0;
          min_per[c] = SatPeriod;
          max_per[c] = '0;
        end
      end
      if (clr_sum) begin
        for (int c = 0; c < NumCh; c++) edge_sum[c] = '0;
      end
      for (int c = 0; c < NumCh; c++) begin
        if (active[c] && run_per[c] != SatPeriod) run_per[c] = run_per[c] + 16'd1;
        fell[c] = !lvl[c] && prev_lvl[c];
        if (fell[c]) begin
          falls++;
          win_cnt[c]  = win_cnt[c] + 16'd1;
          edge_sum[c] = edge_sum[c] + 32'd1;
          // first edge of a channel only starts the period counter
          if (active[c]) begin
            held_per[c] = run_per[c];
            if (run_per[c] < min_per[c]) min_per[c] = run_per[c];
            if (run_per[c] > max_per[c] && run_per[c] != SatPeriod) max_per[c] = run_per[c];
          end
          run_per[c] = '0;
          active[c]  = 1'b1;
        end
        prev_lvl[c] = lvl[c];
      end
      tick_count = tick_count + 8'd1;
      if (tick_count == divide) begin
        tick_count = '0;
        strobe     = 1'b1;
        strobes++;
      end
      for (int c = 0; c < NumCh; c++) begin
        r.channel           = ChW'(c);
        r.lane.edge_seen    = fell[c];
        r.lane.period       = held_per[c];
        r.lane.min_period   = min_per[c];
        r.lane.max_period   = max_per[c];
        r.lane.window_count = win_cnt[c];
        r.lane.running_sum  = edge_sum[c];
        r.ms_strobe         = strobe;
        r.last              = (r.channel == LastCh);
        expected_q.push_back(r);
      end
    endfunction

    function bit differs(string fld, logic [31:0] e, logic [31:0] a);
      if (e === a) return 1'b0;
      if (mismatches < 10) $display("mismatch on %s: expected %0d, got %0d", fld, e, a);
      return 1'b1;
    endfunction

    function void check_result(meter_result_t act);
      meter_result_t e;
      bit            bad;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("result for channel %0d with nothing expected", act.channel);
        mismatches++;
        return;
      end
      e   = expected_q.pop_front();
      bad = 1'b0;
      bad |= differs("channel", 32'(e.channel), 32'(act.channel));
      bad |= differs("edge_seen", 32'(e.lane.edge_seen), 32'(act.lane.edge_seen));
      bad |= differs("period", 32'(e.lane.period), 32'(act.lane.period));
      bad |= differs("min_period", 32'(e.lane.min_period), 32'(act.lane.min_period));
      bad |= differs("max_period", 32'(e.lane.max_period), 32'(act.lane.max_period));
      bad |= differs("window_count", 32'(e.lane.window_count), 32'(act.lane.window_count));
      bad |= differs("running_sum", e.lane.running_sum, act.lane.running_sum);
      bad |= differs("ms_strobe", 32'(e.ms_strobe), 32'(act.ms_strobe));
      bad |= differs("last", 32'(e.last), 32'(act.last));
      if (bad) begin
        if (mismatches < 10) $display("  in result %0d, channel %0d", checked, e.channel);
        mismatches++;
      end
      if (act.lane.edge_seen && act.lane.period == SatPeriod) saturated++;
      checked++;
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  pmm_in_if  tick_if ();
  pmm_out_if res_if ();

  multi_channel_pulse_period_meter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tick_i      (tick_if),
    .res_o       (res_if)
  );

  always #5 clk_i = ~clk_i;

  meter_scoreboard sb;
  logic [2:0]  levels;
  bit          send_idle;
  bit          recv_idle;
  int unsigned ticks_sent;

  logic [4:0] directed_ticks [20] = '{
    5'h00, 5'h07, 5'h00, 5'h07, 5'h00, 5'h07, 5'h07, 5'h00, 5'h05, 5'h02,
    5'h01, 5'h0F, 5'h08, 5'h10, 5'h17, 5'h18, 5'h1F, 5'h00, 5'h00, 5'h00
  };

  task automatic send_tick(logic [2:0] lvl, logic clr_win, logic clr_sum);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 14) : 0;
    if ($urandom_range(0, 19) == 0) send_idle = !send_idle;
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_if.valid        <= 1'b1;
    tick_if.pin_zero     <= lvl[0];
    tick_if.pin_one      <= lvl[1];
    tick_if.pin_two      <= lvl[2];
    tick_if.clear_window <= clr_win;
    tick_if.clear_sum    <= clr_sum;
    do @(posedge clk_i); while (!tick_if.ready);
    sb.note_tick(lvl, clr_win, clr_sum);
    ticks_sent++;
    levels = lvl;
  endtask

  // register writes only once every result of the phase is out
  task automatic write_divide(logic [7:0] v);
    tick_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_divide(v);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int unsigned count);
    int unsigned pct [NumCh];
    logic [2:0]  lvl;
    for (int c = 0; c < NumCh; c++) pct[c] = $urandom_range(5, 90);
    for (int unsigned i = 0; i < count; i++) begin
      lvl = levels;
      if ($urandom_range(0, 24) == 0) begin
        lvl = 3'($urandom_range(0, 7));
      end else begin
        for (int c = 0; c < NumCh; c++)
          if ($urandom_range(0, 99) < pct[c]) lvl[c] = !lvl[c];
      end
      send_tick(lvl, $urandom_range(0, 15) == 0, $urandom_range(0, 23) == 0);
    end
  endtask

  // result side: random stalls between result transactions
  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = recv_idle ? $urandom_range(0, 14) : 0;
      if ($urandom_range(0, 29) == 0) recv_idle = !recv_idle;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
      sb.check_result('{channel: res_if.channel,
                        lane: '{edge_seen: res_if.edge_seen, period: res_if.period,
                                min_period: res_if.min_period,
                                max_period: res_if.max_period,
                                window_count: res_if.window_count,
                                running_sum: res_if.running_sum},
                        ms_strobe: res_if.ms_strobe, last: res_if.last});
    end
  end

  initial begin
    sb         = new();
    levels     = '0;
    send_idle  = 1'b1;
    recv_idle  = 1'b1;
    ticks_sent = 0;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    tick_if.valid        <= 1'b0;
    tick_if.pin_zero     <= 1'b0;
    tick_if.pin_one      <= 1'b0;
    tick_if.pin_two      <= 1'b0;
    tick_if.clear_window <= 1'b0;
    tick_if.clear_sum    <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_ticks[i])
      send_tick(directed_ticks[i][2:0], directed_ticks[i][3], directed_ticks[i][4]);

    write_divide(8'd1);
    run_random(40);
    write_divide(8'd255);
    run_random(60);
    // zero divider, written below the running count
    write_divide(8'd0);
    run_random(200);
    write_divide(8'($urandom_range(8, 60)));
    run_random(80);
    write_divide(TickDivRst);
    run_random(20);

    tick_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("%0d ticks sent, %0d results checked, %0d falling edges, %0d strobes",
             ticks_sent, sb.checked, sb.falls, sb.strobes);
    $display("%0d saturated periods seen, %0d mismatches", sb.saturated, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Verification failed");
    $finish;
  end

endmodule
